// ===== rtl/core/awmm_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC window minimum monitor: shared definitions
// Field widths, item kinds, register indexes, result flag positions and the
// sequencer state type.
// ----------------------------------------------------------------------------
package awmm_pkg;

  localparam int QW     = 18;
  localparam int MV_W   = 17;
  localparam int TS_W   = 32;
  localparam int SEQ_W  = 32;
  localparam int CNT_W  = 7;
  localparam int GAIN_W = 16;
  localparam int REF_W  = 13;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 3;
  localparam int MODE_W = 2;
  localparam int OUT_USER_W = 3;

  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HISTORY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STATUS  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_CODE_OFFSET   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REF_MV        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_Q12      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN_MIN_Q12  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GAIN_MAX_Q12  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BUS_OFFSET_MV = 3'd5;
  localparam logic [CFG_AW-1:0] REG_WINDOW_MS     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_STALE_MS      = 3'd7;

  localparam int OUT_STALE  = 0;
  localparam int OUT_EMPTY  = 1;
  localparam int OUT_CLOSED = 2;

  localparam logic signed [MV_W-1:0] MV_MAX = 17'sh0FFFF;
  localparam logic signed [MV_W-1:0] MV_MIN = 17'sh10000;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_PREP   = 16'h0002,
    ST_MUL1   = 16'h0004,
    ST_MUL2   = 16'h0008,
    ST_RND    = 16'h0010,
    ST_DIV    = 16'h0020,
    ST_ADD    = 16'h0040,
    ST_FIN    = 16'h0080,
    ST_STAT   = 16'h0100,
    ST_HCHK   = 16'h0200,
    ST_HCLAMP = 16'h0400,
    ST_HBACK  = 16'h0800,
    ST_HIDX   = 16'h1000,
    ST_HREAD  = 16'h2000,
    ST_HDATA  = 16'h4000,
    ST_HEMPTY = 16'h8000
  } state_t;

endpackage

// ===== rtl/core/awmm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module awmm_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/adc_window_min_monitor_with_history.sv =====
// ----------------------------------------------------------------------------
// ADC window minimum monitor with ring history
// Converts ADC samples to bus millivolts, logs them with timestamps, tracks the
// windowed minimum and serves history and status reads.
// ----------------------------------------------------------------------------
// Sample: two multiplier passes, then shift-and-add passes divide by full scale
//   (12-bit codes) before the result beat.
// History read: one beat per entry read, or a single empty beat when none is
//   available. Ready returns the cycle after the last beat loads.
// Reset: synchronous; clears sequencer, registers, window and cache state. The
//   history RAM is not cleared; reads never reach unwritten entries.
module adc_window_min_monitor_with_history
  import awmm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256,
  parameter int MAX_BURST     = 64,
  parameter int ADC_BITS      = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_AW-1:0]                   cfg_addr,
  input  logic [CFG_W-1:0]                    cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // adc_code, now_ms, start_seq, max_count
  input  logic [((ADC_BITS+78)/8)*8-1:0]      s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]                   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // voltage_mv, raw_code, time_ms, next_seq
  output logic [((ADC_BITS+88)/8)*8-1:0]      m_axis_tdata,
  // stale, empty_res, window_closed
  output logic [OUT_USER_W-1:0]               m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int OUT_W = ((ADC_BITS + 88) / 8) * 8;
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int BW    = $clog2(HISTORY_DEPTH + 1);
  localparam int PA_W  = ADC_BITS + REF_W;
  localparam int PM_W  = PA_W + GAIN_W;
  localparam int NW    = PM_W + 1;
  localparam int ZW    = NW - 12;
  localparam int HW    = ZW - ADC_BITS;
  localparam int RAM_W = MV_W + TS_W;

  localparam logic [NW-1:0] DEN      = NW'(((64'd1 << ADC_BITS) - 64'd1) << 12);
  localparam logic [NW-1:0] HALF_DEN = DEN >> 1;
  localparam logic signed [19:0] SUM_MAX = 20'sd65535;
  localparam logic signed [19:0] SUM_MIN = -20'sd65536;

  // configuration
  logic [ADC_BITS-1:0]      code_offset;
  logic [REF_W-1:0]         ref_mv;
  logic [GAIN_W-1:0]        gain_q12;
  logic [GAIN_W-1:0]        gain_min_q12;
  logic [GAIN_W-1:0]        gain_max_q12;
  logic signed [15:0]       bus_offset_mv;
  logic [15:0]              window_ms;
  logic [15:0]              stale_ms;

  // control
  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         left;

  // monitor state
  logic [SEQ_W-1:0]         sample_seq;
  logic [AW-1:0]            wr_idx;
  logic [TS_W-1:0]          window_start_ms;
  logic                     window_open;
  logic signed [MV_W-1:0]   window_min_mv;
  logic [ADC_BITS-1:0]      window_min_code;
  logic signed [MV_W-1:0]   cached_min_mv;
  logic [ADC_BITS-1:0]      cached_code;
  logic [TS_W-1:0]          cached_time_ms;
  logic                     cached_valid;

  // item registers
  logic [ADC_BITS-1:0]      code_r;
  logic [TS_W-1:0]          now_r;
  logic [SEQ_W-1:0]         start_r;
  logic [CNT_W-1:0]         maxc_r;

  // arithmetic unit
  logic [PA_W-1:0]          op_a;
  logic [GAIN_W-1:0]        op_b;
  logic [PM_W-1:0]          mul_out;
  logic [GAIN_W-1:0]        gain_r;
  logic [NW-1:0]            rem_r;
  logic [ZW-1:0]            red_r;
  logic [QW-1:0]            quo_r;
  logic signed [MV_W-1:0]   mv_r;

  // history read
  logic [SEQ_W-1:0]         minseq_r;
  logic [BW-1:0]            back_r;
  logic [SEQ_W-1:0]         seq_r;
  logic [AW-1:0]            rd_idx;

  // result register
  logic signed [MV_W-1:0]   out_mv;
  logic [ADC_BITS-1:0]      out_code;
  logic [TS_W-1:0]          out_time;
  logic [SEQ_W-1:0]         out_seq;
  logic                     out_stale;
  logic                     out_empty;
  logic                     out_closed;
  logic                     out_last;

  logic signed [MV_W-1:0]   o_mv_next;
  logic [ADC_BITS-1:0]      o_code_next;
  logic [TS_W-1:0]          o_time_next;
  logic [SEQ_W-1:0]         o_seq_next;
  logic                     o_stale_next;
  logic                     o_empty_next;
  logic                     o_closed_next;
  logic                     o_last_next;
  logic                     out_load;

  // combinational helpers
  logic                     in_fire;
  logic                     out_free;
  logic [ADC_BITS-1:0]      in_code;
  logic [TS_W-1:0]          in_now;
  logic [SEQ_W-1:0]         in_start;
  logic [CNT_W-1:0]         in_maxc;
  logic [ADC_BITS-1:0]      corrected;
  logic [GAIN_W-1:0]        gain_lo;
  logic [GAIN_W-1:0]        gain_clamped;
  logic [NW-1:0]            rnd_sum;
  logic [HW-1:0]            red_hi;
  logic [ADC_BITS-1:0]      red_lo;
  logic                     red_done;
  logic signed [19:0]       sum;
  logic signed [MV_W-1:0]   sum_sat;
  logic                     win_close;
  logic [SEQ_W-1:0]         back_full;
  logic [CNT_W-1:0]         avail_a;
  logic [CNT_W-1:0]         avail;
  logic [SEQ_W-1:0]         start_clamped;
  logic [BW:0]              wr_ext;
  logic [BW:0]              back_ext;
  logic [BW:0]              idx_sum;
  logic [AW-1:0]            rd_idx_inc;
  logic [AW-1:0]            wr_idx_inc;
  logic                     ram_we;
  logic                     ram_re;
  logic [RAM_W-1:0]         ram_rdata;

  assign in_code  = s_axis_tdata[ADC_BITS-1:0];
  assign in_now   = s_axis_tdata[ADC_BITS +: TS_W];
  assign in_start = s_axis_tdata[ADC_BITS+TS_W +: SEQ_W];
  assign in_maxc  = s_axis_tdata[ADC_BITS+TS_W+SEQ_W +: CNT_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign corrected    = (code_r > code_offset) ? code_r - code_offset : '0;
  assign gain_lo      = (gain_q12 < gain_min_q12) ? gain_min_q12 : gain_q12;
  assign gain_clamped = (gain_lo > gain_max_q12) ? gain_max_q12 : gain_lo;
  assign mul_out      = PM_W'(op_a) * PM_W'(op_b);

  // fold by full scale: hi * 2^n + lo = hi * (2^n - 1) + (hi + lo)
  assign rnd_sum  = rem_r + HALF_DEN;
  assign red_hi   = red_r[ZW-1:ADC_BITS];
  assign red_lo   = red_r[ADC_BITS-1:0];
  assign red_done = (red_hi == '0);

  assign sum     = 20'(signed'({2'b00, quo_r})) + 20'(bus_offset_mv);
  assign sum_sat = (sum > SUM_MAX) ? MV_MAX : (sum < SUM_MIN) ? MV_MIN : sum[MV_W-1:0];

  assign win_close = window_open && ((now_r - window_start_ms) >= TS_W'(window_ms));

  assign back_full     = sample_seq - start_r;
  assign avail_a       = (back_full > SEQ_W'(maxc_r)) ? maxc_r : back_full[CNT_W-1:0];
  assign avail         = (avail_a > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : avail_a;
  assign start_clamped = (start_r < minseq_r) ? minseq_r :
                         (start_r > sample_seq) ? sample_seq : start_r;

  assign wr_ext   = (BW+1)'(wr_idx);
  assign back_ext = (BW+1)'(back_r);
  assign idx_sum  = (wr_ext >= back_ext) ? wr_ext - back_ext
                                         : wr_ext + (BW+1)'(HISTORY_DEPTH) - back_ext;
  assign rd_idx_inc = (rd_idx == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
  assign wr_idx_inc = (wr_idx == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_idx + 1'b1;

  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    o_mv_next     = '0;
    o_code_next   = '0;
    o_time_next   = '0;
    o_seq_next    = '0;
    o_stale_next  = 1'b0;
    o_empty_next  = 1'b0;
    o_closed_next = 1'b0;
    o_last_next   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            MODE_SAMPLE:  state_next = ST_PREP;
            MODE_HISTORY: state_next = ST_HCHK;
            MODE_STATUS:  state_next = ST_STAT;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_PREP: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_RND;
      ST_RND:  state_next = ST_DIV;
      ST_DIV: begin
        if (red_done) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          ram_we        = 1'b1;
          o_mv_next     = mv_r;
          o_code_next   = code_r;
          o_time_next   = now_r;
          o_seq_next    = sample_seq + 1'b1;
          o_closed_next = win_close;
          state_next    = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_mv_next    = cached_min_mv;
          o_code_next  = cached_code;
          o_time_next  = cached_time_ms;
          o_seq_next   = sample_seq;
          o_stale_next = !cached_valid || ((now_r - cached_time_ms) > TS_W'(stale_ms));
          state_next   = ST_IDLE;
        end
      end
      ST_HCHK: begin
        if (maxc_r == '0 || sample_seq == '0) begin
          state_next = ST_HEMPTY;
        end else begin
          state_next = ST_HCLAMP;
        end
      end
      ST_HCLAMP: state_next = ST_HBACK;
      ST_HBACK: begin
        if (avail == '0) begin
          state_next = ST_HEMPTY;
        end else begin
          state_next = ST_HIDX;
        end
      end
      ST_HIDX: state_next = ST_HREAD;
      ST_HREAD: begin
        ram_re     = 1'b1;
        state_next = ST_HDATA;
      end
      ST_HDATA: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_mv_next   = ram_rdata[RAM_W-1 -: MV_W];
          o_time_next = ram_rdata[TS_W-1:0];
          o_seq_next  = seq_r;
          o_last_next = (left == CNT_W'(1));
          state_next  = (left == CNT_W'(1)) ? ST_IDLE : ST_HREAD;
        end
      end
      ST_HEMPTY: begin
        if (out_free) begin
          out_load     = 1'b1;
          o_seq_next   = start_r;
          o_empty_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      left            <= '0;
      code_offset     <= '0;
      ref_mv          <= REF_W'(3300);
      gain_q12        <= GAIN_W'(4096);
      gain_min_q12    <= '0;
      gain_max_q12    <= '1;
      bus_offset_mv   <= '0;
      window_ms       <= 16'd300;
      stale_ms        <= 16'd1000;
      sample_seq      <= '0;
      wr_idx          <= '0;
      window_start_ms <= '0;
      window_open     <= 1'b0;
      window_min_mv   <= MV_MAX;
      window_min_code <= '0;
      cached_min_mv   <= '0;
      cached_code     <= '0;
      cached_time_ms  <= '0;
      cached_valid    <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CODE_OFFSET:   code_offset   <= cfg_wdata[ADC_BITS-1:0];
          REG_REF_MV:        ref_mv        <= cfg_wdata[REF_W-1:0];
          REG_GAIN_Q12:      gain_q12      <= cfg_wdata;
          REG_GAIN_MIN_Q12:  gain_min_q12  <= cfg_wdata;
          REG_GAIN_MAX_Q12:  gain_max_q12  <= cfg_wdata;
          REG_BUS_OFFSET_MV: bus_offset_mv <= signed'(cfg_wdata);
          REG_WINDOW_MS:     window_ms     <= cfg_wdata;
          REG_STALE_MS:      stale_ms      <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == ST_HBACK) begin
        left <= avail;
      end else if (state == ST_HDATA && out_free) begin
        left <= left - 1'b1;
      end
      if (state == ST_FIN && out_free) begin
        sample_seq <= sample_seq + 1'b1;
        wr_idx     <= wr_idx_inc;
        if (win_close) begin
          cached_min_mv  <= window_min_mv;
          cached_code    <= window_min_code;
          cached_time_ms <= now_r;
          cached_valid   <= 1'b1;
        end
        if (!window_open || win_close) begin
          window_open     <= 1'b1;
          window_start_ms <= now_r;
          window_min_mv   <= mv_r;
          window_min_code <= code_r;
        end else if (mv_r < window_min_mv) begin
          window_min_mv   <= mv_r;
          window_min_code <= code_r;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          code_r  <= in_code;
          now_r   <= in_now;
          start_r <= in_start;
          maxc_r  <= in_maxc;
        end
      end
      ST_PREP: begin
        op_a   <= PA_W'(corrected);
        op_b   <= GAIN_W'(ref_mv);
        gain_r <= gain_clamped;
      end
      ST_MUL1: begin
        op_a <= mul_out[PA_W-1:0];
        op_b <= gain_r;
      end
      ST_MUL2: rem_r <= NW'(mul_out);
      ST_RND: begin
        red_r <= rnd_sum[NW-1:12];
        quo_r <= '0;
      end
      ST_DIV: begin
        if (red_done) begin
          quo_r <= quo_r + QW'(red_lo == '1);
        end else begin
          quo_r <= quo_r + QW'(red_hi);
          red_r <= ZW'(red_hi) + ZW'(red_lo);
        end
      end
      ST_ADD: mv_r <= sum_sat;
      ST_HCHK: begin
        minseq_r <= (sample_seq > SEQ_W'(HISTORY_DEPTH)) ?
                    sample_seq - SEQ_W'(HISTORY_DEPTH) : '0;
      end
      ST_HCLAMP: start_r <= start_clamped;
      ST_HBACK: begin
        back_r <= back_full[BW-1:0];
        seq_r  <= start_r + 1'b1;
      end
      ST_HIDX: rd_idx <= idx_sum[AW-1:0];
      ST_HDATA: begin
        if (out_free) begin
          rd_idx <= rd_idx_inc;
          seq_r  <= seq_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_mv     <= o_mv_next;
      out_code   <= o_code_next;
      out_time   <= o_time_next;
      out_seq    <= o_seq_next;
      out_stale  <= o_stale_next;
      out_empty  <= o_empty_next;
      out_closed <= o_closed_next;
      out_last   <= o_last_next;
    end
  end

  assign m_axis_tdata = OUT_W'({out_seq, out_time, out_code, out_mv});
  assign m_axis_tuser = {out_closed, out_empty, out_stale};
  assign m_axis_tlast = out_last;

  awmm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata ({mv_r, now_r}),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/awmm_checker.sv =====
// ----------------------------------------------------------------------------
// ADC window minimum monitor: port checker
// Watches the stream ports of the monitor over time; bound to the top level.
// ----------------------------------------------------------------------------
module awmm_checker
  import awmm_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [CFG_AW-1:0]              cfg_addr,
  input logic [CFG_W-1:0]               cfg_wdata,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [((ADC_BITS+78)/8)*8-1:0] s_axis_tdata,
  input logic [MODE_W-1:0]              s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [((ADC_BITS+88)/8)*8-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0]          m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser == MODE_SAMPLE || s_axis_tuser == MODE_HISTORY ||
     s_axis_tuser == MODE_STATUS) |=> !s_axis_tready)
    else $error("input ready while an item is in work");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[OUT_EMPTY] |->
      m_axis_tlast && m_axis_tdata[MV_W-1:0] == '0 && !m_axis_tuser[OUT_CLOSED] &&
      !m_axis_tuser[OUT_STALE])
    else $error("empty history beat malformed");

  a_closed_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[OUT_CLOSED] |->
      m_axis_tlast && !m_axis_tuser[OUT_STALE])
    else $error("window close flag on a non-sample beat");

endmodule

bind adc_window_min_monitor_with_history awmm_checker #(
  .ADC_BITS (ADC_BITS)
) u_awmm_checker (.*);
